>>> hw/rtl/pn2d_pkg.sv
// Package for the 2D gradient noise block: permutation table and output constants.
package pn2d_pkg;

    localparam int OUT_W = 18;
    localparam int OUT_FRAC = 16;
    localparam int OUT_LIMIT = 98304;
    localparam int IN_W = 24;

    typedef logic [7:0] t_hash;

    localparam t_hash PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
        8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
        8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
        8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
        8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
        8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
        8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,
        8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
        8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
        8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
        8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
        8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
        8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
        8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
        8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,
        8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,
        8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
        8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
        8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
        8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
        8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
        8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

endpackage

>>> hw/rtl/perlin_noise_2d.sv
// Top level of the 2D gradient noise pipeline.
//
// Usage:
//   - Input channel: drive i_x_coord / i_y_coord (unsigned, FRAC_BITS fraction
//     bits, integer part wraps modulo 256) and raise start. A transfer happens
//     at each rising edge with start high and busy low. busy is never raised,
//     so one sample can be issued on every clock.
//   - Result channel: o_valid is high for exactly one cycle per sample with
//     o_noise_value (signed, 16 fraction bits, -98304..98304) beside it.
//   - Throughput: one sample per cycle. The result strobe follows the input
//     transfer through the nine-register pipeline (input register, four
//     fade/hash stages, three blend stages, output register); the x blend
//     stage holds two multiplies, every other stage at most one.
//   - Results leave in input order. The receiver cannot stall; none is needed
//     as the pipeline never holds an item.
//   - Reset (i_rst_n low, synchronous) clears the valid chain, dropping any
//     samples in flight; the data registers are not reset.
module perlin_noise_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pn2d_pkg::IN_W-1:0]        i_x_coord,
    input  logic [pn2d_pkg::IN_W-1:0]        i_y_coord,
    output logic                             o_valid,
    output logic signed [pn2d_pkg::OUT_W-1:0] o_noise_value
);
    localparam int DW  = FRAC_BITS + 6;       // blend operands
    localparam int MW  = FRAC_BITS + 2 + DW;  // weight times difference
    localparam int SH  = FRAC_BITS + 1 - pn2d_pkg::OUT_FRAC;
    localparam int XW  = DW + 8;              // output scaling headroom
    localparam int LAT = 8;
    localparam logic signed [MW-1:0] HALF = MW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [XW-1:0] LIM_HI = XW'(pn2d_pkg::OUT_LIMIT);
    localparam logic signed [XW-1:0] LIM_LO = -XW'(pn2d_pkg::OUT_LIMIT);

    // valid chain, index k is valid for stage k
    logic [LAT:0]            r_vld;
    logic                    accept;

    // coordinates padded so the lattice bits exist for any fraction width
    logic [pn2d_pkg::IN_W+7:0] x_ext, y_ext;

    // stage 0: input register
    logic [7:0]              r_xi, r_yi;
    logic [FRAC_BITS-1:0]    r_xf, r_yf;

    logic [FRAC_BITS:0]      wu4, wv4;
    logic signed [DW-1:0]    p0_4, dq0_4, p1_4, dq1_4;

    logic [FRAC_BITS:0]      r_wv5, r_wv6;
    logic signed [DW-1:0]    r_row0_5, r_row1_5, r_row0_6, r_diff6, r_val7;
    logic signed [XW-1:0]    scaled;
    logic signed [pn2d_pkg::OUT_W-1:0] r_out;

    function automatic logic signed [DW-1:0] lerp(input logic signed [DW-1:0] p,
                                                  input logic signed [DW-1:0] dq,
                                                  input logic [FRAC_BITS:0] w);
        logic signed [MW-1:0] prod;
        logic signed [MW-1:0] s;
        prod = $signed(MW'(w)) * MW'(dq);
        s = (prod + HALF) >>> FRAC_BITS;
        lerp = p + s[DW-1:0];
    endfunction

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign x_ext  = {8'd0, i_x_coord};
    assign y_ext  = {8'd0, i_y_coord};

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk (i_clk),
        .i_f   (r_xf),
        .o_w   (wu4)
    );

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk (i_clk),
        .i_f   (r_yf),
        .o_w   (wv4)
    );

    pn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
        .i_clk (i_clk),
        .i_xi  (r_xi),
        .i_yi  (r_yi),
        .i_xf  (r_xf),
        .i_yf  (r_yf),
        .o_p0  (p0_4),
        .o_dq0 (dq0_4),
        .o_p1  (p1_4),
        .o_dq1 (dq1_4)
    );

    // final scaling to 16 fraction bits, round to nearest, ties up
    generate
        if (SH > 0) begin : g_down
            localparam logic signed [XW-1:0] RHALF = XW'(1) <<< (SH - 1);
            always_comb begin
                scaled = (XW'(r_val7) + RHALF) >>> SH;
            end
        end else begin : g_up
            always_comb begin
                scaled = XW'(r_val7) <<< (-SH);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xi <= x_ext[FRAC_BITS +: 8];
            r_yi <= y_ext[FRAC_BITS +: 8];
            r_xf <= i_x_coord[FRAC_BITS-1:0];
            r_yf <= i_y_coord[FRAC_BITS-1:0];
        end
        // stage 5: blend along x for both rows
        r_row0_5 <= lerp(p0_4, dq0_4, wu4);
        r_row1_5 <= lerp(p1_4, dq1_4, wu4);
        r_wv5    <= wv4;
        // stage 6: row difference
        r_row0_6 <= r_row0_5;
        r_diff6  <= r_row1_5 - r_row0_5;
        r_wv6    <= r_wv5;
        // stage 7: blend along y
        r_val7   <= lerp(r_row0_6, r_diff6, r_wv6);
        // stage 8: scale and clamp
        if (scaled > LIM_HI) begin
            r_out <= pn2d_pkg::OUT_W'(pn2d_pkg::OUT_LIMIT);
        end else if (scaled < LIM_LO) begin
            r_out <= -pn2d_pkg::OUT_W'(pn2d_pkg::OUT_LIMIT);
        end else begin
            r_out <= scaled[pn2d_pkg::OUT_W-1:0];
        end
    end

    assign o_valid       = r_vld[LAT];
    assign o_noise_value = r_out;

endmodule

>>> hw/rtl/pn2d_fade.sv
// Four-stage quintic fade pipeline, one multiply per stage.
module pn2d_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic [FRAC_BITS-1:0] i_f,
    output logic [FRAC_BITS:0]   o_w
);
    localparam int FW = FRAC_BITS + 5;
    localparam int PW = FRAC_BITS + 1 + FW;
    localparam logic signed [FW-1:0] C15 = FW'(15) <<< FRAC_BITS;
    localparam logic signed [FW-1:0] C10 = FW'(10) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic [FRAC_BITS-1:0]   r_t1, r_t2, r_t3;
    logic signed [FW-1:0]   r_b, r_c, r_d;
    logic signed [FW-1:0]   fe, a, w_full;

    // round to nearest, ties up
    function automatic logic signed [FW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + HALF) >>> FRAC_BITS;
        rnd = s[FW-1:0];
    endfunction

    function automatic logic signed [PW-1:0] mul(input logic [FRAC_BITS-1:0] t,
                                                 input logic signed [FW-1:0] m);
        logic signed [PW-1:0] tp;
        tp = $signed(PW'(t));
        mul = tp * PW'(m);
    endfunction

    always_comb begin
        fe = $signed(FW'(i_f));
        a = (fe <<< 2) + (fe <<< 1) - C15;
        w_full = rnd(mul(r_t3, r_d));
    end

    always_ff @(posedge i_clk) begin
        r_t1 <= i_f;
        r_b  <= rnd(mul(i_f, a)) + C10;
        r_t2 <= r_t1;
        r_c  <= rnd(mul(r_t1, r_b));
        r_t3 <= r_t2;
        r_d  <= rnd(mul(r_t2, r_c));
        o_w  <= w_full[FRAC_BITS:0];
    end

endmodule

>>> hw/rtl/pn2d_hash.sv
// Lattice hashing through the permutation table and corner gradients, four stages.
module pn2d_hash #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic [7:0]                  i_xi,
    input  logic [7:0]                  i_yi,
    input  logic [FRAC_BITS-1:0]        i_xf,
    input  logic [FRAC_BITS-1:0]        i_yf,
    output logic signed [FRAC_BITS+5:0] o_p0,
    output logic signed [FRAC_BITS+5:0] o_dq0,
    output logic signed [FRAC_BITS+5:0] o_p1,
    output logic signed [FRAC_BITS+5:0] o_dq1
);
    localparam int GW = FRAC_BITS + 4;
    localparam int DW = FRAC_BITS + 6;
    localparam logic signed [GW-1:0] ONE = GW'(1) <<< FRAC_BITS;

    pn2d_pkg::t_hash        r_px0, r_px1, r_yi1;
    pn2d_pkg::t_hash        r_haa, r_hab, r_hba, r_hbb;
    logic [FRAC_BITS-1:0]   r_xf1, r_yf1, r_xf2, r_yf2;
    logic signed [GW-1:0]   r_gaa, r_gba, r_gab, r_gbb;
    logic signed [GW-1:0]   x0, y0, x1, y1;

    function automatic logic signed [GW-1:0] grad(input pn2d_pkg::t_hash h,
                                                  input logic signed [GW-1:0] dx,
                                                  input logic signed [GW-1:0] dy);
        logic signed [GW-1:0] u, v;
        u = h[2] ? dy : dx;
        v = h[2] ? dx : dy;
        if (h[0]) begin
            u = -u;
        end
        v = v <<< 1;
        if (h[1]) begin
            v = -v;
        end
        grad = u + v;
    endfunction

    always_comb begin
        x0 = $signed(GW'(r_xf2));
        y0 = $signed(GW'(r_yf2));
        x1 = x0 - ONE;
        y1 = y0 - ONE;
    end

    always_ff @(posedge i_clk) begin
        // stage 1: row permutation
        r_px0 <= pn2d_pkg::PERM[i_xi];
        r_px1 <= pn2d_pkg::PERM[i_xi + 8'd1];
        r_yi1 <= i_yi;
        r_xf1 <= i_xf;
        r_yf1 <= i_yf;
        // stage 2: corner hashes
        r_haa <= pn2d_pkg::PERM[r_px0 + r_yi1];
        r_hab <= pn2d_pkg::PERM[r_px0 + r_yi1 + 8'd1];
        r_hba <= pn2d_pkg::PERM[r_px1 + r_yi1];
        r_hbb <= pn2d_pkg::PERM[r_px1 + r_yi1 + 8'd1];
        r_xf2 <= r_xf1;
        r_yf2 <= r_yf1;
        // stage 3: gradients
        r_gaa <= grad(r_haa, x0, y0);
        r_gba <= grad(r_hba, x1, y0);
        r_gab <= grad(r_hab, x0, y1);
        r_gbb <= grad(r_hbb, x1, y1);
        // stage 4: blend operands
        o_p0  <= DW'(r_gaa);
        o_dq0 <= DW'(r_gba) - DW'(r_gaa);
        o_p1  <= DW'(r_gab);
        o_dq1 <= DW'(r_gbb) - DW'(r_gab);
    end

endmodule

>>> hw/rtl/pn2d_chk.sv
// Port-level checker for the 2D gradient noise block, bound to the top level.
module pn2d_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [pn2d_pkg::OUT_W-1:0] o_noise_value
);
    // edges from the transfer edge to the edge that takes the result
    localparam int LAT = 9;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without transfer");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_noise_value <= 18'sd98304 && o_noise_value >= -18'sd98304))
        else $error("noise value out of range");

endmodule

bind perlin_noise_2d pn2d_chk u_pn2d_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_noise_value (o_noise_value)
);
